// ===== rtl/bcdtfa_pkg.sv =====
package bcdtfa_pkg;

   // Command codes carried by one request beat.
   localparam logic [1:0] CMD_LOAD_TIME = 2'd0;
   localparam logic [1:0] CMD_INC       = 2'd1;
   localparam logic [1:0] CMD_DEC       = 2'd2;
   localparam logic [1:0] CMD_LOAD_SET  = 2'd3;

   // Field selector codes.
   localparam logic [3:0] FS_NONE     = 4'd0;
   localparam logic [3:0] FS_HOUR     = 4'd1;
   localparam logic [3:0] FS_MINUTE   = 4'd2;
   localparam logic [3:0] FS_FORMAT   = 4'd3;
   localparam logic [3:0] FS_MONTH    = 4'd4;
   localparam logic [3:0] FS_DAY      = 4'd5;
   localparam logic [3:0] FS_WEEK     = 4'd6;
   localparam logic [3:0] FS_YEAR     = 4'd7;
   localparam logic [3:0] FS_BEEP     = 4'd8;
   localparam logic [3:0] FS_ALARM_HR = 4'd9;
   localparam logic [3:0] FS_ALARM_MN = 4'd10;
   localparam logic [3:0] FS_FLIP     = 4'd11;
   localparam logic [3:0] FS_NIGHT    = 4'd12;

   // Write target codes reported with each result beat.
   localparam logic [2:0] WT_TIME     = 3'd0;
   localparam logic [2:0] WT_FLAGS    = 3'd1;
   localparam logic [2:0] WT_ALARM_HR = 3'd2;
   localparam logic [2:0] WT_ALARM_MN = 3'd3;
   localparam logic [2:0] WT_NONE     = 3'd4;

   // BCD bounds and hour encodings.
   localparam logic [7:0] BCD_MAX      = 8'h99;
   localparam logic [7:0] BCD_MIN_MAX  = 8'h59;
   localparam logic [7:0] BCD_HR_MAX   = 8'h23;
   localparam logic [7:0] BCD_MON_MAX  = 8'h12;
   localparam logic [7:0] HOUR_AM12    = 8'h92;
   localparam logic [7:0] HOUR_PM12    = 8'hB2;
   localparam logic [7:0] HOUR_PM_BASE = 8'hA0;
   localparam logic [7:0] HOUR_AM_BASE = 8'h80;
   localparam logic [7:0] DAYS_31      = 8'h31;
   localparam logic [7:0] DAYS_30      = 8'h30;
   localparam logic [7:0] DAYS_28      = 8'h28;
   localparam logic [7:0] WEEK_MAX     = 8'h07;

   // Controller to datapath command group.
   typedef struct packed {
      logic capture;
   } ctrl_cmd_type;

endpackage

// ===== rtl/bcdtfa_ctrl.sv =====
module bcdtfa_ctrl
   import bcdtfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   localparam logic ST_EMPTY = 1'b0;
   localparam logic ST_FULL  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // A new beat may enter when the result slot is empty or is being drained.
   assign req_ready   = (state_ff == ST_EMPTY) || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = (state_ff == ST_FULL);
   assign cmd.capture = accept;

   // Next state of the result slot.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!accept && rsp_ready) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_EMPTY;
      else       state_ff <= state_in;
   end

endmodule

// ===== rtl/bcdtfa_dp.sv =====
module bcdtfa_dp
   import bcdtfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  logic [1:0]   command,
   input  logic [3:0]   field_select,
   input  logic [7:0]   load_second,
   input  logic [7:0]   load_minute,
   input  logic [7:0]   load_hour,
   input  logic [7:0]   load_day,
   input  logic [7:0]   load_month,
   input  logic [2:0]   load_week,
   input  logic [7:0]   load_year,
   input  logic [7:0]   load_alarm_hour,
   input  logic [7:0]   load_alarm_minute,
   input  logic [2:0]   load_flags,
   output logic [7:0]   second,
   output logic [7:0]   minute,
   output logic [7:0]   hour,
   output logic [7:0]   day,
   output logic [7:0]   month,
   output logic [2:0]   week,
   output logic [7:0]   year,
   output logic [7:0]   alarm_hour,
   output logic [7:0]   alarm_minute,
   output logic [2:0]   settings_flags,
   output logic [2:0]   write_target
);

   // Step up with wrap to the lower bound and BCD carry.
   function automatic logic [7:0] step_up(input logic [7:0] v, input logic [7:0] top,
                                          input logic [7:0] bottom);
      logic [7:0] r;
      if (v >= top || v == BCD_MAX) r = bottom;
      else if (v[3:0] == 4'h9)      r = {v[7:4] + 4'h1, 4'h0};
      else                          r = v + 8'h01;
      return r;
   endfunction

   // Step down with wrap to the upper bound and BCD borrow.
   function automatic logic [7:0] step_down(input logic [7:0] v, input logic [7:0] top,
                                            input logic [7:0] bottom);
      logic [7:0] r;
      if (v <= bottom || v == 8'h00) r = top;
      else if (v[3:0] == 4'h0)       r = v - 8'h07;
      else                           r = v - 8'h01;
      return r;
   endfunction

   // Binary 0..99 to two BCD digits; tens found by parallel compares.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] rem;
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (v >= 7'(k * 10)) tens = 4'(k);
      end
      rem = v - 7'(tens) * 7'd10;
      return {tens, rem[3:0]};
   endfunction

   // Days in a BCD month; meaningless months give zero.
   function automatic logic [7:0] month_days(input logic [7:0] m);
      logic [7:0] r;
      unique case (m)
         8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12: r = DAYS_31;
         8'h04, 8'h06, 8'h09, 8'h11:                      r = DAYS_30;
         8'h02:                                           r = DAYS_28;
         default:                                         r = 8'h00;
      endcase
      return r;
   endfunction

   logic [7:0] second_ff, minute_ff, hour_ff, day_ff, month_ff, year_ff;
   logic [7:0] alarm_hr_ff, alarm_min_ff;
   logic [2:0] week_ff, flags_ff, wt_ff;
   logic [7:0] second_in, minute_in, hour_in, day_in, month_in, year_in;
   logic [7:0] alarm_hr_in, alarm_min_in;
   logic [2:0] week_in, flags_in, wt_in;

   logic       up;
   logic [4:0] h12_val;
   logic [5:0] plain12;
   logic [6:0] h24_val;
   logic [5:0] p2h_arg;
   logic [5:0] p2h_less;
   logic [7:0] p2h_val;
   logic [6:0] h24_next;
   logic [6:0] h24_less;
   logic [7:0] hour_step;
   logic [7:0] hour_toggle;
   logic [7:0] day_lim;
   logic [1:0] year_mod4;
   logic [7:0] week_step;

   assign up = (command == CMD_INC);

   // Hour digits in both encodings.
   assign h12_val = hour_ff[4] ? (5'd10 + {1'b0, hour_ff[3:0]}) : {1'b0, hour_ff[3:0]};
   always_comb begin
      if (hour_ff[5]) plain12 = (h12_val == 5'd12) ? 6'd12 : ({1'b0, h12_val} + 6'd12);
      else            plain12 = (h12_val == 5'd12) ? 6'd0 : {1'b0, h12_val};
   end
   assign h24_val = 7'(hour_ff[6:4]) * 7'd10 + {3'b000, hour_ff[3:0]};

   // Plain hour back to the 12-hour encoding.
   always_comb begin
      if (up)                  p2h_arg = plain12 + 6'd1;
      else if (plain12 == 6'd0) p2h_arg = 6'd23;
      else                     p2h_arg = plain12 - 6'd1;
      p2h_less = p2h_arg - 6'd12;
      if (p2h_arg >= 6'd12) begin
         if (p2h_less == 6'd0) p2h_val = HOUR_PM12;
         else                  p2h_val = HOUR_PM_BASE | to_bcd({1'b0, p2h_less});
      end else begin
         p2h_val = HOUR_AM_BASE | to_bcd({1'b0, p2h_arg});
      end
   end

   // Hour step in either format.
   always_comb begin
      if (up) h24_next = (h24_val + 7'd1 > 7'd23) ? 7'd0 : (h24_val + 7'd1);
      else    h24_next = (h24_val == 7'd0) ? 7'd23 : (h24_val - 7'd1);
      if (hour_ff[7]) begin
         if (up && p2h_arg > 6'd23)       hour_step = HOUR_AM12;
         else if (!up && p2h_arg == 6'd0) hour_step = HOUR_AM12;
         else                             hour_step = p2h_val;
      end else begin
         hour_step = to_bcd(h24_next);
      end
   end

   // Conversion between 12-hour and 24-hour form.
   always_comb begin
      h24_less = h24_val - 7'd12;
      if (hour_ff[7]) begin
         if (hour_ff[5])                       hour_toggle = to_bcd({1'b0, plain12});
         else if ({3'b000, hour_ff[4:0]} == BCD_MON_MAX) hour_toggle = 8'h00;
         else                                  hour_toggle = {3'b000, hour_ff[4:0]};
      end else if (hour_ff >= BCD_MON_MAX) begin
         hour_toggle = (h24_less == 7'd0) ? HOUR_PM12 : (HOUR_PM_BASE | to_bcd(h24_less));
      end else if (hour_ff == 8'h00) begin
         hour_toggle = HOUR_AM12;
      end else begin
         hour_toggle = HOUR_AM_BASE | hour_ff;
      end
   end

   // Day limit with the leap day in February.
   assign year_mod4 = {year_ff[4], 1'b0} + year_ff[1:0];
   assign day_lim   = month_days(month_ff) +
                      ((month_ff == 8'h02 && year_mod4 == 2'd0) ? 8'h01 : 8'h00);

   assign week_step = up ? step_up({5'b0, week_ff}, WEEK_MAX, 8'h01)
                         : step_down({5'b0, week_ff}, WEEK_MAX, 8'h01);

   // Next register set for the command in the current beat.
   always_comb begin
      second_in    = second_ff;
      minute_in    = minute_ff;
      hour_in      = hour_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      week_in      = week_ff;
      year_in      = year_ff;
      alarm_hr_in  = alarm_hr_ff;
      alarm_min_in = alarm_min_ff;
      flags_in     = flags_ff;
      wt_in        = WT_NONE;
      unique case (command)
         CMD_LOAD_TIME: begin
            second_in = load_second;
            minute_in = load_minute;
            hour_in   = load_hour;
            day_in    = load_day;
            month_in  = load_month;
            week_in   = load_week;
            year_in   = load_year;
         end
         CMD_LOAD_SET: begin
            alarm_hr_in  = (load_alarm_hour > BCD_HR_MAX) ? 8'h00 : load_alarm_hour;
            alarm_min_in = (load_alarm_minute > BCD_MIN_MAX) ? 8'h00 : load_alarm_minute;
            flags_in     = load_flags;
         end
         default: begin
            unique case (field_select)
               FS_HOUR: begin
                  hour_in = hour_step;
                  wt_in   = WT_TIME;
               end
               FS_MINUTE: begin
                  minute_in = up ? step_up(minute_ff, BCD_MIN_MAX, 8'h00)
                                 : step_down(minute_ff, BCD_MIN_MAX, 8'h00);
                  second_in = 8'h00;
                  wt_in     = WT_TIME;
               end
               FS_FORMAT: begin
                  hour_in = hour_toggle;
                  wt_in   = WT_TIME;
               end
               FS_MONTH: begin
                  month_in = up ? step_up(month_ff, BCD_MON_MAX, 8'h01)
                                : step_down(month_ff, BCD_MON_MAX, 8'h01);
                  wt_in    = WT_TIME;
               end
               FS_DAY: begin
                  day_in = up ? step_up(day_ff, day_lim, 8'h01)
                              : step_down(day_ff, day_lim, 8'h01);
                  wt_in  = WT_TIME;
               end
               FS_WEEK: begin
                  week_in = week_step[2:0];
                  wt_in   = WT_TIME;
               end
               FS_YEAR: begin
                  year_in = up ? step_up(year_ff, BCD_MAX, 8'h00)
                               : step_down(year_ff, BCD_MAX, 8'h00);
                  wt_in   = WT_TIME;
               end
               FS_BEEP: begin
                  flags_in = flags_ff ^ 3'b001;
                  wt_in    = WT_FLAGS;
               end
               FS_ALARM_HR: begin
                  alarm_hr_in = up ? step_up(alarm_hr_ff, BCD_HR_MAX, 8'h00)
                                   : step_down(alarm_hr_ff, BCD_HR_MAX, 8'h00);
                  wt_in       = WT_ALARM_HR;
               end
               FS_ALARM_MN: begin
                  alarm_min_in = up ? step_up(alarm_min_ff, BCD_MIN_MAX, 8'h00)
                                    : step_down(alarm_min_ff, BCD_MIN_MAX, 8'h00);
                  wt_in        = WT_ALARM_MN;
               end
               FS_FLIP: begin
                  flags_in = flags_ff ^ 3'b010;
                  wt_in    = WT_FLAGS;
               end
               FS_NIGHT: begin
                  flags_in = flags_ff ^ 3'b100;
                  wt_in    = WT_FLAGS;
               end
               default: wt_in = WT_NONE;
            endcase
         end
      endcase
   end

   // Register set; updated only when a request beat is captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff    <= 8'h00;
         minute_ff    <= 8'h00;
         hour_ff      <= 8'h00;
         day_ff       <= 8'h01;
         month_ff     <= 8'h01;
         week_ff      <= 3'd1;
         year_ff      <= 8'h00;
         alarm_hr_ff  <= 8'h00;
         alarm_min_ff <= 8'h00;
         flags_ff     <= 3'b000;
      end else if (cmd.capture) begin
         second_ff    <= second_in;
         minute_ff    <= minute_in;
         hour_ff      <= hour_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         week_ff      <= week_in;
         year_ff      <= year_in;
         alarm_hr_ff  <= alarm_hr_in;
         alarm_min_ff <= alarm_min_in;
         flags_ff     <= flags_in;
      end
   end

   // Write target of the result beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) wt_ff <= wt_in;
   end

   assign second         = second_ff;
   assign minute         = minute_ff;
   assign hour           = hour_ff;
   assign day            = day_ff;
   assign month          = month_ff;
   assign week           = week_ff;
   assign year           = year_ff;
   assign alarm_hour     = alarm_hr_ff;
   assign alarm_minute   = alarm_min_ff;
   assign settings_flags = flags_ff;
   assign write_target   = wt_ff;

endmodule

// ===== rtl/bcd_time_field_adjuster.sv =====
// The result beat is valid in the cycle after its request beat is accepted.
// Throughput: one command per cycle while rsp_ready stays high; the single register
// stage of the time register set holds the result until it is taken.
// Reset (synchronous, active high) sets time to 00:00:00, day 01, month 01,
// weekday 1, year 00, alarm 00:00, flags clear, and empties the result slot.
module bcd_time_field_adjuster
   import bcdtfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [3:0] req_field_select,
   input  logic [7:0] req_load_second,
   input  logic [7:0] req_load_minute,
   input  logic [7:0] req_load_hour,
   input  logic [7:0] req_load_day,
   input  logic [7:0] req_load_month,
   input  logic [2:0] req_load_week,
   input  logic [7:0] req_load_year,
   input  logic [7:0] req_load_alarm_hour,
   input  logic [7:0] req_load_alarm_minute,
   input  logic [2:0] req_load_flags,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_second,
   output logic [7:0] rsp_minute,
   output logic [7:0] rsp_hour,
   output logic [7:0] rsp_day,
   output logic [7:0] rsp_month,
   output logic [2:0] rsp_week,
   output logic [7:0] rsp_year,
   output logic [7:0] rsp_alarm_hour,
   output logic [7:0] rsp_alarm_minute,
   output logic [2:0] rsp_settings_flags,
   output logic [2:0] rsp_write_target
);

   ctrl_cmd_type cmd;

   bcdtfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bcdtfa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .command           (req_command),
      .field_select      (req_field_select),
      .load_second       (req_load_second),
      .load_minute       (req_load_minute),
      .load_hour         (req_load_hour),
      .load_day          (req_load_day),
      .load_month        (req_load_month),
      .load_week         (req_load_week),
      .load_year         (req_load_year),
      .load_alarm_hour   (req_load_alarm_hour),
      .load_alarm_minute (req_load_alarm_minute),
      .load_flags        (req_load_flags),
      .second            (rsp_second),
      .minute            (rsp_minute),
      .hour              (rsp_hour),
      .day               (rsp_day),
      .month             (rsp_month),
      .week              (rsp_week),
      .year              (rsp_year),
      .alarm_hour        (rsp_alarm_hour),
      .alarm_minute      (rsp_alarm_minute),
      .settings_flags    (rsp_settings_flags),
      .write_target      (rsp_write_target)
   );

   // An accepted beat always produces a result beat in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat did not produce a result");

   // A pending result is never overwritten by a new beat.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while result stalled");

   // An unused selector reports no write.
   a_none_target: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_INC || req_command == CMD_DEC) &&
      req_field_select == FS_NONE |=> rsp_write_target == WT_NONE)
      else $error("unused selector reported a write");

   // Weekday stepping never yields zero.
   a_week_nonzero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_INC || req_command == CMD_DEC) &&
      req_field_select == FS_WEEK |=> rsp_week != 3'd0)
      else $error("weekday step produced zero");

endmodule
